[hw/rtl/clt_pkg.sv]
// Shared constants, codes and types for the community value list table.
package clt_pkg;

    // List geometry.
    localparam int CAPACITY = 255;
    localparam int CNT_W    = 8;
    localparam int VAL_W    = 32;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_ADD      = 3'd0;
    localparam logic [2:0] MODE_REMOVE   = 3'd1;
    localparam logic [2:0] MODE_CONTAINS = 3'd2;
    localparam logic [2:0] MODE_READ     = 3'd3;
    localparam logic [2:0] MODE_CLEAR    = 3'd4;

    // Status codes returned with every result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Per-cell control from the controller.
    typedef struct packed {
        logic shift;    // move one place toward the head this cycle
        logic at_tail;  // this cell is the last one of the live list
        logic wr;       // load the appended value
    } cell_ctrl_t;

    // One result beat.
    typedef struct packed {
        logic [VAL_W-1:0] entry_value;
        logic [CNT_W-1:0] count;
        logic             found;
        logic [1:0]       status;
    } result_t;

endpackage

[hw/rtl/clt_cell.sv]
// One storage cell of the list chain: holds one entry and shifts toward the head.
module clt_cell (
    input  logic                        clk,
    input  clt_pkg::cell_ctrl_t         ctrl,
    input  logic [clt_pkg::VAL_W-1:0]   nbr_data,
    input  logic [clt_pkg::VAL_W-1:0]   tail_data,
    input  logic [clt_pkg::VAL_W-1:0]   wr_data,
    output logic [clt_pkg::VAL_W-1:0]   data
);
    import clt_pkg::*;

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;

    // An append loads the new value; a shift takes the neighbor, or the
    // recirculated head when this cell closes the ring.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.wr)
        begin
            data_next = wr_data;
        end
        else if (ctrl.shift)
        begin
            data_next = ctrl.at_tail ? tail_data : nbr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[hw/rtl/community_value_list_table.sv]
// Top level of the community value list table: cell chain and its controller.
//
// Usage: one request beat on the s_ channel gives exactly one result beat on
// the m_ channel. The mode in s_tuser selects add, remove all matches,
// contains, read entry or clear; every result reports the entry count after
// the operation.
// The list lives in a chain of CAPACITY cells, entry 0 at the head. Add,
// clear, an out-of-range read, unused mode codes and any operation on an
// empty list finish in the accept cycle, and the result is valid on the next
// cycle. Remove, contains and an in-range read rotate the live part of the
// chain once, one entry per cycle, and load the result with the last entry.
// Remove drops matching entries as they pass the head, which compacts the
// list while keeping its order.
// A new request is taken only while no operation is running and the result
// register is empty or being emptied, so a stalled receiver holds off the
// next request and no result is lost. Reset empties the list; the cells
// themselves are not cleared.
module community_value_list_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value [31:0], index [39:32]
    input  logic [2:0]  s_tuser,   // mode [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status [1:0], found [2], count [10:3],
                                   // entry_value [42:11], zero [47:43]
);
    import clt_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]       mode_reg, mode_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] last_reg, last_next;
    logic             found_reg, found_next;
    logic [VAL_W-1:0] rd_reg, rd_next;
    logic             m_valid_reg, m_valid_next;
    result_t          res_reg, res_next;

    logic             accept;
    logic [2:0]       in_mode;
    logic [VAL_W-1:0] in_value;
    logic [CNT_W-1:0] in_index;
    logic             scan_start;
    logic             last_step;
    logic             head_match;
    logic             shift;
    logic             append;
    logic             res_load;

    logic [VAL_W-1:0] cell_data [CAPACITY];
    cell_ctrl_t       cell_ctrl [CAPACITY];

    // Unpack the request beat.
    assign in_mode  = s_tuser;
    assign in_value = s_tdata[31:0];
    assign in_index = s_tdata[39:32];

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign head_match = (cell_data[0] == value_reg);
    assign last_step  = (step_reg == last_reg);

    // Operations that need a pass over a non-empty list.
    always_comb
    begin
        scan_start = 1'b0;
        if (count_reg != '0)
        begin
            if ((in_mode == MODE_REMOVE) || (in_mode == MODE_CONTAINS))
            begin
                scan_start = 1'b1;
            end
            else if ((in_mode == MODE_READ) && (in_index < count_reg))
            begin
                scan_start = 1'b1;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && scan_start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and result formation.
    always_comb
    begin
        mode_next  = mode_reg;
        value_next = value_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        found_next = found_reg;
        rd_next    = rd_reg;
        shift      = 1'b0;
        append     = 1'b0;
        res_load   = 1'b0;
        res_next   = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_mode;
                    value_next = in_value;
                    idx_next   = in_index;
                    step_next  = '0;
                    last_next  = count_reg - 1'b1;
                    found_next = 1'b0;
                    rd_next    = '0;
                    res_next   = '0;
                    res_next.count = count_reg;
                    res_load   = !scan_start;
                    unique case (in_mode)
                        MODE_ADD:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                append         = 1'b1;
                                count_next     = count_reg + 1'b1;
                                res_next.count = count_reg + 1'b1;
                            end
                        end
                        MODE_READ:
                        begin
                            if (in_index >= count_reg)
                            begin
                                res_next.status = STATUS_RANGE;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next     = '0;
                            res_next.count = '0;
                        end
                        default:
                        begin
                            // Remove and contains on an empty list, and unused
                            // codes, report the count unchanged.
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                shift     = 1'b1;
                step_next = step_reg + 1'b1;
                if (head_match && (mode_reg == MODE_REMOVE))
                begin
                    count_next = count_reg - 1'b1;
                    found_next = 1'b1;
                end
                if (head_match && (mode_reg == MODE_CONTAINS))
                begin
                    found_next = 1'b1;
                end
                if ((mode_reg == MODE_READ) && (step_reg == idx_reg))
                begin
                    rd_next = cell_data[0];
                end
                if (last_step)
                begin
                    res_load             = 1'b1;
                    res_next.status      = STATUS_OK;
                    res_next.found       = found_next;
                    res_next.count       = count_next;
                    res_next.entry_value = rd_next;
                end
            end
            default:
            begin
            end
        endcase

        if (res_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Operation and result payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        value_reg <= value_next;
        idx_reg   <= idx_next;
        step_reg  <= step_next;
        last_reg  <= last_next;
        found_reg <= found_next;
        rd_reg    <= rd_next;
        res_reg   <= res_next;
    end

    // The cell chain: cell 0 is the head, the live list closes into a ring
    // at cell count-1 during a pass.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_ctrl[i].shift   = shift;
        assign cell_ctrl[i].at_tail = (count_reg == CNT_W'(i + 1));
        assign cell_ctrl[i].wr      = append && (count_reg == CNT_W'(i));

        if (i == CAPACITY - 1)
        begin : g_last
            clt_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[i]),
                .nbr_data  (cell_data[0]),
                .tail_data (cell_data[0]),
                .wr_data   (value_next),
                .data      (cell_data[i])
            );
        end
        else
        begin : g_mid
            clt_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[i]),
                .nbr_data  (cell_data[i + 1]),
                .tail_data (cell_data[0]),
                .wr_data   (value_next),
                .data      (cell_data[i])
            );
        end
    end

    // Result beat.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, res_reg.entry_value, res_reg.count,
                       res_reg.found, res_reg.status};

endmodule

[verif/community_value_list_table_tb.sv]
// Self-checking testbench for the community value list table.
module community_value_list_table_tb;

    import clt_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int POOL_SIZE     = 12;
    localparam int RANDOM_ITEMS  = 600;
    localparam int HOLD_CYCLES   = 400;

    // Mode codes that the block must treat as no operation.
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // value [31:0], index [39:32]
    logic [2:0]  s_tuser  = '0;   // mode [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // status [1:0], found [2], count [10:3],
                                  // entry_value [42:11], zero [47:43]

    // Shadow copy of the list and the results still owed by the block.
    logic [31:0] community_list[$];
    result_t     expected_results[$];

    logic [31:0] value_pool[POOL_SIZE];
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_request = 0;
    int          mismatch_count = 0;
    longint      cycle_count = 0;

    // Coverage tallies for the summary.
    int          mode_tally[8];
    int          full_adds = 0;
    int          range_reads = 0;
    int          matched_removes = 0;
    int          peak_count = 0;

    community_value_list_table u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // Applies one operation to the shadow list and returns the result it owes.
    function automatic result_t list_op_result(logic [2:0] mode, logic [31:0] value,
                                               logic [7:0] index);
        result_t res;
        int      size_before;
        int      i;
        res = '0;
        case (mode)
            MODE_ADD:
            begin
                if (community_list.size() >= CAPACITY)
                    res.status = STATUS_FULL;
                else
                    community_list.push_back(value);
            end
            MODE_REMOVE:
            begin
                size_before = community_list.size();
                for (i = community_list.size() - 1; i >= 0; i--)
                begin
                    if (community_list[i] == value)
                        community_list.delete(i);
                end
                res.found = (community_list.size() != size_before);
            end
            MODE_CONTAINS:
            begin
                for (i = 0; i < community_list.size(); i++)
                begin
                    if (community_list[i] == value)
                        res.found = 1'b1;
                end
            end
            MODE_READ:
            begin
                if (int'(index) < community_list.size())
                    res.entry_value = community_list[index];
                else
                    res.status = STATUS_RANGE;
            end
            MODE_CLEAR:
                community_list.delete();
            default:
                ;
        endcase
        res.count = CNT_W'(community_list.size());
        return res;
    endfunction

    // Drives one request beat, after a random gap while sender idling is on, and records what it must return.
    task automatic send_op(logic [2:0] mode, logic [31:0] value, logic [7:0] index);
        int      gap;
        result_t res;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {index, value};
        do
            @(posedge clk);
        while (!s_tready);
        res = list_op_result(mode, value, index);
        expected_results.push_back(res);
        mode_tally[mode]++;
        if (mode == MODE_ADD && res.status == STATUS_FULL)
            full_adds++;
        if (mode == MODE_READ && res.status == STATUS_RANGE)
            range_reads++;
        if (mode == MODE_REMOVE && res.found)
            matched_removes++;
        if (int'(res.count) > peak_count)
            peak_count = int'(res.count);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly values from a small pool so that matches and duplicates occur.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Mostly indexes inside the live list, sometimes anywhere in range.
    function automatic logic [7:0] pick_index();
        if (community_list.size() > 0 && $urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, community_list.size() - 1));
        return 8'($urandom_range(0, CAPACITY - 1));
    endfunction

    task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        mismatch_count++;
    endtask

    // Result side: random stalls, long hold-offs on request, and the field checks.
    initial
    begin : result_sink
        result_t got;
        result_t want;
        int      stall_left;
        int      hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[42:0]);
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %0h",
                             $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 32'(want.status), 32'(got.status));
                    if (got.found != want.found)
                        report_mismatch("found", 32'(want.found), 32'(got.found));
                    if (got.count != want.count)
                        report_mismatch("count", 32'(want.count), 32'(got.count));
                    if (got.entry_value != want.entry_value)
                        report_mismatch("entry_value", want.entry_value, got.entry_value);
                    if (m_tdata[47:43] != '0)
                        report_mismatch("padding", 32'd0, 32'(m_tdata[47:43]));
                end
                stall_left = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run exceeded %0d cycles with %0d results outstanding.",
                 CYCLE_LIMIT, expected_results.size());
        $display("TEST FAILED");
        $finish;
    end

    // Extremes of the fields, every mode and the corner cases on a short list.
    task automatic test_directed();
        int m;
        send_op(MODE_READ, 32'h0, 8'd0);
        send_op(MODE_CONTAINS, 32'h0, 8'd0);
        send_op(MODE_REMOVE, 32'h0, 8'd0);
        send_op(MODE_CLEAR, 32'h0, 8'd0);
        for (m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_op(3'(m), 32'hFFFF_FFFF, 8'hFE);
        send_op(MODE_ADD, 32'h0, 8'd0);
        send_op(MODE_ADD, 32'hFFFF_FFFF, 8'hFE);
        send_op(MODE_ADD, 32'h0, 8'd0);
        send_op(MODE_ADD, 32'hA5A5_5A5A, 8'd0);
        for (m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_op(3'(m), 32'h0, 8'd1);
        send_op(MODE_CONTAINS, 32'hFFFF_FFFF, 8'd0);
        send_op(MODE_CONTAINS, 32'h1234_5678, 8'd0);
        send_op(MODE_READ, 32'h0, 8'd1);
        send_op(MODE_READ, 32'h0, 8'd3);
        send_op(MODE_READ, 32'h0, 8'd4);
        send_op(MODE_READ, 32'h0, 8'hFE);
        // Both zero entries go in one remove; the rest keep their order.
        send_op(MODE_REMOVE, 32'h0, 8'd0);
        send_op(MODE_REMOVE, 32'h1234_5678, 8'd0);
        send_op(MODE_READ, 32'h0, 8'd0);
        send_op(MODE_READ, 32'h0, 8'd1);
        send_op(MODE_CLEAR, 32'h0, 8'd0);
        send_op(MODE_READ, 32'h0, 8'd0);
    endtask

    // Fill the list to capacity, push past it, then compact a heavily repeated value.
    task automatic test_capacity();
        int n;
        send_op(MODE_CLEAR, 32'h0, 8'd0);
        for (n = 0; n < CAPACITY; n++)
            send_op(MODE_ADD, value_pool[$urandom_range(0, 3)], pick_index());
        send_op(MODE_ADD, 32'hDEAD_BEEF, 8'd0);
        send_op(MODE_ADD, 32'hFFFF_FFFF, 8'd0);
        send_op(MODE_READ, 32'h0, 8'd254);
        send_op(MODE_READ, 32'h0, 8'd0);
        send_op(MODE_CONTAINS, value_pool[3], 8'd0);
        send_op(MODE_CONTAINS, 32'hDEAD_BEEF, 8'd0);
        send_op(MODE_REMOVE, value_pool[1], 8'd0);
        send_op(MODE_READ, 32'h0, 8'd254);
        for (n = 0; n < 4; n++)
            send_op(MODE_READ, 32'h0, pick_index());
        send_op(MODE_CLEAR, 32'h0, 8'd0);
    endtask

    // Hold the result side off while requests keep coming, then let it all drain.
    task automatic test_backpressure();
        int n;
        for (n = 0; n < 10; n++)
            send_op(MODE_ADD, pick_value(), 8'd0);
        stop_sending();
        wait_results_drained();
        hold_request = HOLD_CYCLES;
        for (n = 0; n < 25; n++)
            send_op(($urandom_range(0, 1) != 0) ? MODE_CONTAINS : MODE_READ,
                    pick_value(), pick_index());
        // Sender pauses until every owed result is back.
        stop_sending();
        wait_results_drained();
        for (n = 0; n < 10; n++)
            send_op(MODE_REMOVE, pick_value(), 8'd0);
    endtask

    // Weighted random operations with idling switched on and off in stretches.
    task automatic test_random();
        int          n;
        int          pick;
        logic [2:0]  mode;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 2) != 0);
                rx_idle_on = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                mode = MODE_ADD;
            else if (pick < 55)
                mode = MODE_REMOVE;
            else if (pick < 75)
                mode = MODE_CONTAINS;
            else if (pick < 95)
                mode = MODE_READ;
            else if (pick < 97)
                mode = MODE_CLEAR;
            else
                mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
            send_op(mode, pick_value(), pick_index());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Test sequence.
    initial
    begin : test_sequence
        int n;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (n = 2; n < POOL_SIZE; n++)
            value_pool[n] = $urandom;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity();
        test_backpressure();
        test_random();

        stop_sending();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d adds, %0d removes, %0d contains, %0d reads, %0d clears,",
                 mode_tally[MODE_ADD], mode_tally[MODE_REMOVE], mode_tally[MODE_CONTAINS],
                 mode_tally[MODE_READ], mode_tally[MODE_CLEAR]);
        $display("  %0d spare modes; peak of %0d entries, %0d adds on a full list,",
                 mode_tally[5] + mode_tally[6] + mode_tally[7], peak_count, full_adds);
        $display("  %0d reads past the end, %0d hits on remove.",
                 range_reads, matched_removes);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
